>>> rtl/svr_pkg.sv
// shared types and constants for the servo status packet receiver
// no dependencies; imported by every rtl module of the block
package svr_pkg;

  localparam logic [1:0] OP_ARM  = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] KIND_PARAM   = 2'd0;
  localparam logic [1:0] KIND_OK      = 2'd1;
  localparam logic [1:0] KIND_CSUM    = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  localparam logic [7:0]  HEADER_BYTE   = 8'hFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'(16 * 1000);
  localparam logic [15:0] TICK_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] sender_id;
    logic       overflowed;
  } result_t;

endpackage

>>> rtl/svr_in_reg.sv
// input register stage: holds one accepted word until the core takes it
// depends on svr_pkg
module svr_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  svr_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output svr_pkg::item_t item
);
  import svr_pkg::*;

  logic take;

  assign in_stall = item_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= in_item;
    end
  end

endmodule

>>> rtl/svr_core.sv
// packet state and combinational parse, checksum and timeout logic
// depends on svr_pkg
module svr_core #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             proc,
  input  svr_pkg::item_t   item,
  input  logic [15:0]      timeout_ticks,
  output logic             res_valid,
  output svr_pkg::result_t res
);
  import svr_pkg::*;

  localparam logic [7:0] BUF_LIMIT = 8'(BUFFER_BYTES);

  logic        armed, armed_next;
  logic [7:0]  byte_count, byte_count_next;
  logic        header_good, header_good_next;
  logic [7:0]  packet_length, packet_length_next;
  logic [7:0]  packet_id, packet_id_next;
  logic [7:0]  status_byte, status_byte_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] tick_count, tick_count_next;
  logic        overflow_flag, overflow_flag_next;

  logic [8:0] check_pos;
  logic       in_body;

  always_comb begin
    armed_next         = armed;
    byte_count_next    = byte_count;
    header_good_next   = header_good;
    packet_length_next = packet_length;
    packet_id_next     = packet_id;
    status_byte_next   = status_byte;
    running_sum_next   = running_sum;
    tick_count_next    = tick_count;
    overflow_flag_next = overflow_flag;
    res_valid          = 1'b0;
    res.kind           = KIND_PARAM;
    res.value          = 8'd0;
    res.sender_id      = packet_id;
    res.overflowed     = overflow_flag;
    check_pos          = 9'd0;
    in_body            = 1'b0;

    if (proc) begin
      case (item.opcode)
        OP_ARM: begin
          armed_next         = 1'b1;
          byte_count_next    = 8'd0;
          header_good_next   = 1'b0;
          packet_length_next = 8'd0;
          packet_id_next     = 8'd0;
          status_byte_next   = 8'd0;
          running_sum_next   = 8'd0;
          tick_count_next    = 16'd0;
          overflow_flag_next = 1'b0;
        end
        OP_BYTE: begin
          if (armed) begin
            if (byte_count >= BUF_LIMIT) begin
              overflow_flag_next = 1'b1;
            end else begin
              byte_count_next = byte_count + 8'd1;
              case (byte_count)
                8'd0: header_good_next = (item.data_byte == HEADER_BYTE);
                8'd1: header_good_next = header_good && (item.data_byte == HEADER_BYTE);
                8'd2: packet_id_next = item.data_byte;
                8'd3: packet_length_next = item.data_byte;
                8'd4: status_byte_next = item.data_byte;
                default: ;
              endcase
              check_pos = {1'b0, packet_length_next} + 9'd3;
              in_body   = (byte_count >= 8'd2) && ({1'b0, byte_count} < check_pos);
              if (in_body) begin
                running_sum_next = running_sum + item.data_byte;
              end
              res.sender_id = packet_id_next;
              if (header_good_next && byte_count >= 8'd3) begin
                if ({1'b0, byte_count} >= check_pos) begin
                  armed_next = 1'b0;
                  res_valid  = 1'b1;
                  res.kind   = (~running_sum == item.data_byte) ? KIND_OK : KIND_CSUM;
                  res.value  = status_byte_next;
                end else if (byte_count >= 8'd5) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_PARAM;
                  res.value = item.data_byte;
                end
              end
            end
          end
        end
        OP_TICK: begin
          if (armed) begin
            if (tick_count != TICK_MAX) begin
              tick_count_next = tick_count + 16'd1;
            end
            if (tick_count_next >= timeout_ticks) begin
              armed_next = 1'b0;
              res_valid  = 1'b1;
              res.kind   = KIND_TIMEOUT;
              res.value  = 8'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed         <= 1'b0;
      byte_count    <= 8'd0;
      header_good   <= 1'b0;
      packet_length <= 8'd0;
      packet_id     <= 8'd0;
      status_byte   <= 8'd0;
      running_sum   <= 8'd0;
      tick_count    <= 16'd0;
      overflow_flag <= 1'b0;
    end else begin
      armed         <= armed_next;
      byte_count    <= byte_count_next;
      header_good   <= header_good_next;
      packet_length <= packet_length_next;
      packet_id     <= packet_id_next;
      status_byte   <= status_byte_next;
      running_sum   <= running_sum_next;
      tick_count    <= tick_count_next;
      overflow_flag <= overflow_flag_next;
    end
  end

`ifndef SYNTH
  a_res_needs_proc: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> proc)
    else $error("result without a word being processed");

  a_outcome_disarms: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind != KIND_PARAM) |=> !armed)
    else $error("receiver still armed after an outcome");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_count <= BUF_LIMIT)
    else $error("byte count past buffer capacity");

  a_arm_clears: assert property (@(posedge clk) disable iff (rst)
    (proc && item.opcode == OP_ARM) |=> (armed && byte_count == 8'd0 && !overflow_flag))
    else $error("arm did not restart reception");
`endif

endmodule

>>> rtl/svr_out_reg.sv
// result register: holds one result word until the receiver takes it
// depends on svr_pkg
module svr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  svr_pkg::result_t res,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_stall,
  output svr_pkg::result_t out_res
);
  import svr_pkg::*;

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

endmodule

>>> rtl/servo_status_packet_receiver.sv
// Servo bus status packet receiver. Takes one word per clock while in_stall is low (arm,
// received byte or timer tick): one register holds the accepted word, the packet state
// updates combinationally behind it, and a result register drives the output. Sustained
// rate is one word per cycle; in_stall follows out_stall only when both registers are
// full. timeout_ticks may be written at any time (cfg_ready is always high) but is meant
// to change only while the block is idle.
// depends on svr_pkg, svr_in_reg, svr_core, svr_out_reg
module servo_status_packet_receiver #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  value,
  output logic [7:0]  sender_id,
  output logic        overflowed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] timeout_ticks
);
  import svr_pkg::*;

  logic [15:0] timeout_reg;
  item_t       in_item;
  item_t       item;
  logic        item_valid;
  logic        advance;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_reg <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_reg <= timeout_ticks;
    end
  end

  assign in_item.opcode    = opcode;
  assign in_item.data_byte = data_byte;

  svr_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  svr_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .proc          (item_valid && advance),
    .item          (item),
    .timeout_ticks (timeout_reg),
    .res_valid     (res_valid),
    .res           (res)
  );

  svr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign kind       = out_res.kind;
  assign value      = out_res.value;
  assign sender_id  = out_res.sender_id;
  assign overflowed = out_res.overflowed;

endmodule
